// ===== rtl/core/mrt_pkg.sv =====
// shared constants and types for the mesh route table
package mrt_pkg;
  localparam int TableEntries = 64;
  localparam int IdxW = $clog2(TableEntries);
  localparam int CntW = $clog2(TableEntries + 1);

  localparam logic [2:0] CMD_ADD_LOCAL = 3'd0;
  localparam logic [2:0] CMD_REM_LOCAL = 3'd1;
  localparam logic [2:0] CMD_ADD_HOP   = 3'd2;
  localparam logic [2:0] CMD_REM_RELAY = 3'd3;
  localparam logic [2:0] CMD_REM_HOP   = 3'd4;
  localparam logic [2:0] CMD_LOOKUP    = 3'd5;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_OWN      = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NO_ROUTE = 2'd3;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_DIRECT = 2'd1;
  localparam logic [1:0] KIND_RELAY  = 2'd2;

  typedef struct packed {
    logic [7:0]  node;
    logic [7:0]  relay;
    logic        active;
    logic [31:0] seen;
  } entry_t;
endpackage

// ===== rtl/core/mrt_ram.sv =====
// entry store: one write port, one registered read port
module mrt_ram (
  input  logic                clk,
  input  logic                we,
  input  logic [mrt_pkg::IdxW-1:0] waddr,
  input  mrt_pkg::entry_t     wdata,
  input  logic [mrt_pkg::IdxW-1:0] raddr,
  output mrt_pkg::entry_t     rdata
);
  import mrt_pkg::*;
  entry_t mem [TableEntries];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/mesh_route_table.sv =====
// Mesh route table: up to 64 entries kept in insertion order in one RAM with a registered
// read. One transaction at a time: the sequencer scans the n stored entries one per cycle,
// refreshing, marking stale or compacting the tail in place as it goes, then finishes and
// presents the result. A lookup that falls back to the relay pass scans a second time.
// Own-id rejects and unknown commands answer in the cycle after acceptance. in_stall is
// high from acceptance until the result is taken, so out_stall holds off the next
// transaction.
module mesh_route_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [7:0]  in_node_id,
  input  logic [7:0]  in_relay_id,
  input  logic        in_active_flag,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [1:0]  out_route_kind,
  output logic [7:0]  out_next_hop_id,
  output logic [6:0]  out_removed_count
);
  import mrt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_FIN = 3'd2,
                         S_SCAN2 = 3'd3, S_OUT = 3'd4;

  logic [2:0] state_r;
  logic [7:0] own_r;
  logic [15:0] lim_r;
  logic [2:0] cmd_r;
  logic [7:0] node_r, relay_r;
  logic act_r;
  logic [31:0] now_r;
  logic [CntW-1:0] count_r, rd_r, wr_r, hit_r;
  logic rvalid_r, found_r, direct_r, best_r;
  logic [7:0] best_relay_r;
  logic [1:0] st_r, kind_r;
  logic [7:0] hop_r;
  logic [CntW-1:0] rem_r;

  logic we;
  logic [IdxW-1:0] waddr, raddr;
  entry_t wdata, rdata;

  mrt_ram u_ram (.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
                 .raddr(raddr), .rdata(rdata));

  logic [7:0] key_relay;
  logic match_pair, match_relay, age_gt, age_lt, is_rem;
  logic [31:0] age;
  always_comb begin
    key_relay = (cmd_r == CMD_ADD_LOCAL || cmd_r == CMD_REM_LOCAL) ? own_r : relay_r;
    match_pair = rdata.node == node_r && rdata.relay == key_relay;
    match_relay = rdata.relay == relay_r;
    age = now_r - rdata.seen;
    age_gt = age > {16'd0, lim_r};
    age_lt = age < {16'd0, lim_r};
    is_rem = cmd_r == CMD_REM_LOCAL || cmd_r == CMD_REM_HOP || cmd_r == CMD_REM_RELAY;
  end

  // scan drop: entry read this cycle is removed (compaction skips it)
  logic drop;
  always_comb begin
    drop = 1'b0;
    if (cmd_r == CMD_REM_RELAY) drop = match_relay;
    else if (is_rem) drop = match_pair && !found_r;
  end

  always_comb begin
    we = 1'b0;
    waddr = wr_r[IdxW-1:0];
    wdata = rdata;
    raddr = rd_r[IdxW-1:0];
    if (state_r == S_SCAN && rvalid_r) begin
      if (is_rem) begin
        we = !drop && (wr_r != hit_r);
      end else if (cmd_r == CMD_LOOKUP) begin
        waddr = hit_r[IdxW-1:0];
        wdata.active = 1'b0;
        we = rdata.node == node_r && rdata.active && rdata.relay == own_r && age_gt;
      end else if (match_pair && !found_r) begin
        waddr = hit_r[IdxW-1:0];
        wdata.active = 1'b1;
        wdata.seen = now_r;
        we = 1'b1;
      end
    end else if (state_r == S_FIN && !found_r &&
                 (cmd_r == CMD_ADD_LOCAL || cmd_r == CMD_ADD_HOP) &&
                 count_r != CntW'(TableEntries)) begin
      we = 1'b1;
      waddr = count_r[IdxW-1:0];
      wdata.node = node_r;
      wdata.relay = key_relay;
      wdata.active = (cmd_r == CMD_ADD_HOP) ? act_r : 1'b1;
      wdata.seen = now_r;
    end
  end

  logic own_hit;
  always_comb begin
    case (in_command)
      CMD_ADD_LOCAL, CMD_REM_LOCAL: own_hit = in_node_id == own_r;
      CMD_ADD_HOP, CMD_REM_HOP: own_hit = in_node_id == own_r || in_relay_id == own_r;
      CMD_REM_RELAY: own_hit = in_relay_id == own_r;
      default: own_hit = 1'b0;
    endcase
  end

  assign in_stall = state_r != S_IDLE;
  assign out_valid = state_r == S_OUT;
  assign out_status = st_r;
  assign out_route_kind = kind_r;
  assign out_next_hop_id = hop_r;
  assign out_removed_count = (rem_r > CntW'(127)) ? 7'd127 : 7'(rem_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      own_r <= 8'd0;
      lim_r <= 16'd500;
      count_r <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index) lim_r <= cfg_data;
        else own_r <= cfg_data[7:0];
      end
      case (state_r)
        S_IDLE: if (in_valid) begin
          cmd_r <= in_command; node_r <= in_node_id; relay_r <= in_relay_id;
          act_r <= in_active_flag; now_r <= in_now_ms;
          rd_r <= '0; wr_r <= '0; hit_r <= '0; rem_r <= '0;
          rvalid_r <= 1'b0; found_r <= 1'b0; direct_r <= 1'b0; best_r <= 1'b0;
          st_r <= ST_DONE; kind_r <= KIND_NONE; hop_r <= 8'd0;
          if (own_hit) begin
            st_r <= ST_OWN; state_r <= S_OUT;
          end else if (in_command > CMD_LOOKUP) state_r <= S_OUT;
          else state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (rd_r < count_r) rd_r <= rd_r + 1'b1;
          rvalid_r <= rd_r < count_r;
          if (rvalid_r) begin
            hit_r <= hit_r + 1'b1;
            if (is_rem) begin
              if (drop) begin
                found_r <= cmd_r != CMD_REM_RELAY;
                rem_r <= rem_r + 1'b1;
              end else wr_r <= wr_r + 1'b1;
            end else if (cmd_r == CMD_LOOKUP) begin
              if (rdata.node == node_r) begin
                if (rdata.active && rdata.relay == own_r) begin
                  if (!age_gt) direct_r <= 1'b1;
                end else begin
                  best_r <= 1'b1; best_relay_r <= rdata.relay;
                end
              end
            end else if (match_pair) found_r <= 1'b1;
          end
          if (!(rd_r < count_r) && (rvalid_r || count_r == '0 || rd_r == count_r))
            if (!(rd_r < count_r) && !(rvalid_r && rd_r != count_r) && !rvalid_r ||
                (rvalid_r && rd_r == count_r && !(rd_r < count_r)))
              state_r <= S_FIN;
        end
        S_FIN: begin
          state_r <= S_OUT;
          if (is_rem) count_r <= count_r - rem_r;
          else if (cmd_r == CMD_LOOKUP) begin
            if (direct_r) begin
              kind_r <= KIND_DIRECT; hop_r <= node_r;
            end else if (best_r) begin
              rd_r <= '0; rvalid_r <= 1'b0; found_r <= 1'b0; state_r <= S_SCAN2;
            end else st_r <= ST_NO_ROUTE;
          end else if (!found_r) begin
            if (count_r == CntW'(TableEntries)) st_r <= ST_FULL;
            else count_r <= count_r + 1'b1;
          end
        end
        S_SCAN2: begin
          if (rd_r < count_r) rd_r <= rd_r + 1'b1;
          rvalid_r <= rd_r < count_r;
          if (rvalid_r && !found_r && rdata.node == best_relay_r &&
              rdata.relay == own_r && age_lt) begin
            found_r <= 1'b1; kind_r <= KIND_RELAY; hop_r <= rdata.node;
          end
          if (!(rd_r < count_r) && !rvalid_r) begin
            state_r <= S_OUT;
            if (!found_r) st_r <= ST_NO_ROUTE;
          end
        end
        S_OUT: if (!out_stall) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
